/* rtl/qept_pkg.sv */
`timescale 1ns / 1ps
package qept_pkg;

   localparam int ALPHA_FRAC_BITS = 16;

   localparam int POS_W     = 32;
   localparam int DUR_W     = 32;
   localparam int STEP_W    = 16;
   localparam int ELAPSED_W = 33;
   localparam int DIFF_W    = 33;
   localparam int CSR_IDX_W = 3;

   // alpha in [0, one] and the in-out ratio in [0, two]
   localparam int XW = ALPHA_FRAC_BITS + 1;
   localparam int VW = ALPHA_FRAC_BITS + 2;

   localparam int MUL_AW  = DIFF_W + 1;
   localparam int MUL_BW  = XW + 1;
   localparam int PROD_W  = MUL_AW + MUL_BW;
   localparam int SHIFT_W = PROD_W - ALPHA_FRAC_BITS;
   localparam int SUM_W   = SHIFT_W + 1;

   localparam int DIV_STEPS = ALPHA_FRAC_BITS + 1;
   localparam int DIV_CW    = $clog2(DIV_STEPS);

   localparam int AXES   = 3;
   localparam int AXIS_W = $clog2(AXES);

   localparam logic [XW-1:0] ONE     = XW'(1) << ALPHA_FRAC_BITS;
   localparam logic [VW-1:0] TWO_ONE = VW'(2) << ALPHA_FRAC_BITS;

   localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

   localparam logic OP_RESTART = 1'b1;

   typedef enum logic [1:0] {
      MODE_IN    = 2'd0,
      MODE_OUT   = 2'd1,
      MODE_INOUT = 2'd2,
      MODE_ZERO  = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EASE_MODE = 3'd0,
      CSR_DURATION  = 3'd1,
      CSR_START_X   = 3'd2,
      CSR_START_Y   = 3'd3,
      CSR_START_Z   = 3'd4,
      CSR_END_X     = 3'd5,
      CSR_END_Y     = 3'd6,
      CSR_END_Z     = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic              accept;
      logic              check;
      logic              div_step;
      logic              prep;
      logic              sq1;
      logic              sq2;
      logic              fact;
      logic              lsub;
      logic              lmul;
      logic              ladd;
      logic              load_out;
      logic [AXIS_W-1:0] axis;
   } cmd_type;

   typedef struct packed {
      logic running;
      logic finish;
      logic mode_zero;
      logic dur_zero;
   } status_type;

endpackage

/* rtl/qept_ctrl.sv */
`timescale 1ns / 1ps
module qept_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_opcode,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  qept_pkg::status_type status,
   output qept_pkg::cmd_type    cmd
);
   import qept_pkg::*;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_CHECK = 11'b000_0000_0010,
      ST_DIV   = 11'b000_0000_0100,
      ST_PREP  = 11'b000_0000_1000,
      ST_SQ1   = 11'b000_0001_0000,
      ST_SQ2   = 11'b000_0010_0000,
      ST_FACT  = 11'b000_0100_0000,
      ST_LSUB  = 11'b000_1000_0000,
      ST_LMUL  = 11'b001_0000_0000,
      ST_LADD  = 11'b010_0000_0000,
      ST_OUT   = 11'b100_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [DIV_CW-1:0] div_cnt_ff, div_cnt_in;
   logic [AXIS_W-1:0] axis_ff, axis_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign rsp_valid = rsp_valid_ff;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      div_cnt_in   = div_cnt_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.axis     = axis_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && (req_opcode != OP_RESTART) && status.running) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            if (status.finish || status.mode_zero) begin
               state_in = ST_OUT;
            end else if (status.dur_zero) begin
               state_in = ST_PREP;
            end else begin
               state_in   = ST_DIV;
               div_cnt_in = '0;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CW'(DIV_STEPS - 1)) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_SQ1;
         end
         ST_SQ1: begin
            cmd.sq1  = 1'b1;
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            cmd.sq2  = 1'b1;
            state_in = ST_FACT;
         end
         ST_FACT: begin
            cmd.fact = 1'b1;
            axis_in  = '0;
            state_in = ST_LSUB;
         end
         ST_LSUB: begin
            cmd.lsub = 1'b1;
            state_in = ST_LMUL;
         end
         ST_LMUL: begin
            cmd.lmul = 1'b1;
            state_in = ST_LADD;
         end
         ST_LADD: begin
            cmd.ladd = 1'b1;
            if (axis_ff == AXIS_W'(AXES - 1)) begin
               state_in = ST_OUT;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = ST_LSUB;
            end
         end
         ST_OUT: begin
            // hold until the output register can take the beat
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         div_cnt_ff   <= '0;
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/qept_datapath.sv */
`timescale 1ns / 1ps
module qept_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic        [qept_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [qept_pkg::POS_W-1:0]       csr_wdata,
   input  logic                                    req_opcode,
   input  logic        [qept_pkg::STEP_W-1:0]      req_time_step,
   input  qept_pkg::cmd_type                       cmd,
   output qept_pkg::status_type                    status,
   output logic signed [qept_pkg::POS_W-1:0]       rsp_pos_x,
   output logic signed [qept_pkg::POS_W-1:0]       rsp_pos_y,
   output logic signed [qept_pkg::POS_W-1:0]       rsp_pos_z,
   output logic                                    rsp_finished
);
   import qept_pkg::*;

   mode_type                 mode_ff;
   logic [DUR_W-1:0]         dur_ff;
   logic [POS_W-1:0]         start_ff [AXES];
   logic [POS_W-1:0]         end_ff   [AXES];
   logic [ELAPSED_W-1:0]     elapsed_ff;
   logic                     running_ff;

   logic [DUR_W-1:0]         rem_ff;
   logic [VW-1:0]            quo_ff;
   logic [XW-1:0]            x_ff;
   logic                     lo_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [XW-1:0]            f_ff;
   logic [DIFF_W-1:0]        diff_ff;
   logic [POS_W-1:0]         pos_ff [AXES];
   logic                     fin_ff;
   logic [POS_W-1:0]         out_x_ff, out_y_ff, out_z_ff;
   logic                     out_fin_ff;

   logic [ELAPSED_W-1:0]     elapsed_in;
   logic [ELAPSED_W:0]       cmp;
   logic                     ge;
   logic [DUR_W:0]           shifted;
   logic [DUR_W+1:0]         trial;
   logic [XW-1:0]            u;
   logic                     v_lo;
   logic [XW-1:0]            x_in;
   logic [XW-1:0]            sq;
   logic [XW-1:0]            f_in;
   logic signed [MUL_AW-1:0] mul_a;
   logic signed [MUL_BW-1:0] mul_b;
   logic signed [PROD_W-1:0] mul_p;
   logic [SHIFT_W-1:0]       lerp_q;
   logic [SUM_W-1:0]         sum;
   logic [POS_W-1:0]         sat;
   logic [POS_W-1:0]         s_sel, e_sel;

   assign rsp_pos_x    = out_x_ff;
   assign rsp_pos_y    = out_y_ff;
   assign rsp_pos_z    = out_z_ff;
   assign rsp_finished = out_fin_ff;

   // elapsed against duration: one subtract gives both ge and gt
   assign elapsed_in = elapsed_ff + ELAPSED_W'(req_time_step);
   assign cmp        = {1'b0, elapsed_ff} - {2'b00, dur_ff};
   assign ge         = !cmp[ELAPSED_W];

   assign status.running   = running_ff;
   assign status.finish    = ge && (cmp != '0);
   assign status.mode_zero = (mode_ff == MODE_ZERO);
   assign status.dur_zero  = (dur_ff == '0);

   // restoring divider, one quotient bit per step
   assign shifted = {rem_ff, 1'b0};
   assign trial   = {1'b0, shifted} - {2'b00, dur_ff};

   assign u    = quo_ff[VW-1:1];
   assign v_lo = (quo_ff < VW'(ONE));
   assign sq   = prod_ff[2*ALPHA_FRAC_BITS -: XW];

   assign s_sel = start_ff[cmd.axis];
   assign e_sel = end_ff[cmd.axis];

   always_comb begin
      case (mode_ff)
         MODE_IN:  x_in = u;
         MODE_OUT: x_in = ONE - u;
         default: begin
            if (v_lo) begin
               x_in = quo_ff[XW-1:0];
            end else begin
               x_in = XW'(TWO_ONE - quo_ff);
            end
         end
      endcase
   end

   always_comb begin
      case (mode_ff)
         MODE_IN:  f_in = sq;
         MODE_OUT: f_in = ONE - sq;
         default: begin
            if (lo_ff) begin
               f_in = sq >> 1;
            end else begin
               f_in = ONE - (sq >> 1);
            end
         end
      endcase
   end

   // shared multiplier: squares for the quartic, then one product per axis
   always_comb begin
      if (cmd.lmul) begin
         mul_a = {diff_ff[DIFF_W-1], diff_ff};
         mul_b = {1'b0, f_ff};
      end else if (cmd.sq2) begin
         mul_a = MUL_AW'(sq);
         mul_b = {1'b0, sq};
      end else begin
         mul_a = MUL_AW'(x_ff);
         mul_b = {1'b0, x_ff};
      end
   end

   assign mul_p = mul_a * mul_b;

   assign lerp_q = prod_ff[PROD_W-1:ALPHA_FRAC_BITS];
   assign sum    = {{(SUM_W-POS_W){s_sel[POS_W-1]}}, s_sel} + {lerp_q[SHIFT_W-1], lerp_q};

   always_comb begin
      if ((&sum[SUM_W-1:POS_W-1]) || !(|sum[SUM_W-1:POS_W-1])) begin
         sat = sum[POS_W-1:0];
      end else if (sum[SUM_W-1]) begin
         sat = POS_MIN;
      end else begin
         sat = POS_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_IN;
         dur_ff     <= DUR_W'(1);
         elapsed_ff <= '0;
         running_ff <= 1'b1;
         for (int i = 0; i < AXES; i++) begin
            start_ff[i] <= '0;
            end_ff[i]   <= '0;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_EASE_MODE: mode_ff     <= mode_type'(csr_wdata[1:0]);
               CSR_DURATION:  dur_ff      <= csr_wdata;
               CSR_START_X:   start_ff[0] <= csr_wdata;
               CSR_START_Y:   start_ff[1] <= csr_wdata;
               CSR_START_Z:   start_ff[2] <= csr_wdata;
               CSR_END_X:     end_ff[0]   <= csr_wdata;
               CSR_END_Y:     end_ff[1]   <= csr_wdata;
               CSR_END_Z:     end_ff[2]   <= csr_wdata;
               default:       mode_ff     <= mode_ff;
            endcase
         end
         if (cmd.accept) begin
            if (req_opcode == OP_RESTART) begin
               elapsed_ff <= '0;
               running_ff <= 1'b1;
            end else if (running_ff) begin
               elapsed_ff <= elapsed_in;
            end
         end
         if (cmd.check && status.finish) begin
            running_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         if (status.finish) begin
            for (int i = 0; i < AXES; i++) begin
               pos_ff[i] <= end_ff[i];
            end
            fin_ff <= 1'b1;
         end else if (status.mode_zero) begin
            for (int i = 0; i < AXES; i++) begin
               pos_ff[i] <= '0;
            end
            fin_ff <= 1'b0;
         end else begin
            fin_ff <= 1'b0;
            if (status.dur_zero) begin
               quo_ff <= TWO_ONE;
            end else begin
               // integer bit first; elapsed never exceeds duration here
               quo_ff <= VW'(ge);
               rem_ff <= ge ? cmp[DUR_W-1:0] : elapsed_ff[DUR_W-1:0];
            end
         end
      end
      if (cmd.div_step) begin
         quo_ff <= {quo_ff[VW-2:0], !trial[DUR_W+1]};
         rem_ff <= trial[DUR_W+1] ? shifted[DUR_W-1:0] : trial[DUR_W-1:0];
      end
      if (cmd.prep) begin
         x_ff  <= x_in;
         lo_ff <= v_lo;
      end
      if (cmd.sq1 || cmd.sq2 || cmd.lmul) begin
         prod_ff <= mul_p;
      end
      if (cmd.fact) begin
         f_ff <= f_in;
      end
      if (cmd.lsub) begin
         diff_ff <= {e_sel[POS_W-1], e_sel} - {s_sel[POS_W-1], s_sel};
      end
      if (cmd.ladd) begin
         pos_ff[cmd.axis] <= sat;
      end
      if (cmd.load_out) begin
         out_x_ff   <= pos_ff[0];
         out_y_ff   <= pos_ff[1];
         out_z_ff   <= pos_ff[2];
         out_fin_ff <= fin_ff;
      end
   end

endmodule

/* rtl/quartic_ease_position_tween.sv */
`timescale 1ns / 1ps
// Quartic-eased 3D tween: moves a Q16.16 point from start to end over duration.
// csr_*: register write port (index 0 ease mode, 1 duration, 2..4 start xyz,
//   5..7 end xyz); always ready, write only while the block is idle.
// req_*: one beat per tick. Opcode advance adds time_step to the elapsed time;
//   opcode restart clears it, re-arms the block and gives no result.
// rsp_*: one beat per advance while running: the eased position, or the end
//   point with rsp_finished set once elapsed time passes the duration; after
//   that, advances give nothing until a restart.
// Sequence: an eased result passes the compare, the bit-serial divider, the
//   quartic (prep, two squares, factor), the three axes (subtract, multiply,
//   add per axis) and the output load; a zero duration skips the divider; end
//   point and zero-mode results go from the compare to the output load; a
//   restart or an advance while stopped is handled in the idle state. The
//   bit-serial divider and the single shared multiplier set this sequence.
//   The next request is taken the cycle after the result loads; req_stall is high while busy.
// Reset clears the elapsed time, arms the block and loads the register
//   defaults (ease-in, duration 1, all points zero).
// A stalled result holds in the output register; the next request is taken
//   meanwhile and its result waits for the register to drain.
module quartic_ease_position_tween (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic        [qept_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [qept_pkg::POS_W-1:0]     csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_opcode,
   input  logic        [qept_pkg::STEP_W-1:0]    req_time_step,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [qept_pkg::POS_W-1:0]     rsp_pos_x,
   output logic signed [qept_pkg::POS_W-1:0]     rsp_pos_y,
   output logic signed [qept_pkg::POS_W-1:0]     rsp_pos_z,
   output logic                                  rsp_finished
);
   import qept_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   qept_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   qept_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_opcode    (req_opcode),
      .req_time_step (req_time_step),
      .cmd           (cmd),
      .status        (status),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_pos_z     (rsp_pos_z),
      .rsp_finished  (rsp_finished)
   );

endmodule

/* rtl/qept_checker.sv */
`timescale 1ns / 1ps
module qept_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [qept_pkg::POS_W-1:0]     rsp_pos_x,
   input logic signed [qept_pkg::POS_W-1:0]     rsp_pos_y,
   input logic signed [qept_pkg::POS_W-1:0]     rsp_pos_z,
   input logic                                  rsp_finished
);
   import qept_pkg::*;

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_pos_y)
         && $stable(rsp_pos_z) && $stable(rsp_finished))
      else $error("stalled result beat changed");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a new result is loaded only from the busy phase
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared while the block was idle");

   // going busy needs a request beat
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid))
      else $error("block went busy without a request");

endmodule

bind quartic_ease_position_tween qept_checker u_qept_checker (.*);

/* bench/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import qept_pkg::*;

   localparam logic OP_ADVANCE   = ~OP_RESTART;
   localparam int   RANDOM_ITEMS = 1550;
   localparam int   DRAIN_CYCLES = 40;
   localparam int   QUIET_LIMIT  = 3000;
   localparam int   SCRIPT_LEN   = 37;

   localparam logic [POS_W-1:0] NEG_ONE = 32'hFFFF_0000;
   localparam logic [POS_W-1:0] POS_ONE = 32'h0001_0000;

   typedef struct packed {
      logic [AXES-1:0][POS_W-1:0] pos;
      logic                       done;
   } pos_beat_type;

   typedef enum logic {ROW_REG, ROW_TICK} row_kind_type;
   typedef enum logic [1:0] {CHECK_MODEL, CHECK_NONE, CHECK_GIVEN} check_kind_type;

   typedef struct packed {
      row_kind_type   kind;
      csr_index_type  idx;
      logic [31:0]    data;
      logic           op;
      logic [15:0]    step;
      check_kind_type chk;
      logic [31:0]    want_x;
      logic [31:0]    want_y;
      logic [31:0]    want_z;
      logic           want_done;
   } script_row_type;

   // after reset: ease-in, duration 1, all points zero
   localparam script_row_type SCRIPT [SCRIPT_LEN] = '{
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'd0, CHECK_GIVEN, '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'd1, CHECK_GIVEN, '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'd1, CHECK_GIVEN, '0, '0, '0, 1'b1},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'hFFFF, CHECK_NONE, '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_RESTART, 16'hFFFF, CHECK_NONE, '0, '0, '0, 1'b0},
      '{ROW_REG, CSR_START_X, POS_MIN, OP_ADVANCE, 16'd0, CHECK_NONE, '0, '0, '0, 1'b0},
      '{ROW_REG, CSR_END_X, POS_MAX, OP_ADVANCE, 16'd0, CHECK_NONE, '0, '0, '0, 1'b0},
      '{ROW_REG, CSR_START_Y, POS_MAX, OP_ADVANCE, 16'd0, CHECK_NONE, '0, '0, '0, 1'b0},
      '{ROW_REG, CSR_END_Y, POS_MIN, OP_ADVANCE, 16'd0, CHECK_NONE, '0, '0, '0, 1'b0},
      '{ROW_REG, CSR_START_Z, POS_ONE, OP_ADVANCE, 16'd0, CHECK_NONE, '0, '0, '0, 1'b0},
      '{ROW_REG, CSR_END_Z, NEG_ONE, OP_ADVANCE, 16'd0, CHECK_NONE, '0, '0, '0, 1'b0},
      '{ROW_REG, CSR_DURATION, '1, OP_ADVANCE, 16'd0, CHECK_NONE, '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'hFFFF, CHECK_MODEL, '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'd0, CHECK_MODEL, '0, '0, '0, 1'b0},
      // zero duration: alpha is one right away
      '{ROW_REG, CSR_DURATION, '0, OP_ADVANCE, 16'd0, CHECK_NONE, '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_RESTART, 16'd0, CHECK_NONE, '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'd0, CHECK_GIVEN,
        POS_MAX, POS_MIN, NEG_ONE, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'd1, CHECK_GIVEN,
        POS_MAX, POS_MIN, NEG_ONE, 1'b1},
      '{ROW_REG, CSR_EASE_MODE, 32'(MODE_ZERO), OP_ADVANCE, 16'd0, CHECK_NONE,
        '0, '0, '0, 1'b0},
      '{ROW_REG, CSR_DURATION, 32'd100, OP_ADVANCE, 16'd0, CHECK_NONE, '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_RESTART, 16'd0, CHECK_NONE, '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'd5, CHECK_GIVEN, '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'd200, CHECK_GIVEN,
        POS_MAX, POS_MIN, NEG_ONE, 1'b1},
      '{ROW_REG, CSR_EASE_MODE, 32'(MODE_OUT), OP_ADVANCE, 16'd0, CHECK_NONE,
        '0, '0, '0, 1'b0},
      '{ROW_REG, CSR_DURATION, 32'd1000, OP_ADVANCE, 16'd0, CHECK_NONE, '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_RESTART, 16'd0, CHECK_NONE, '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'd250, CHECK_MODEL, '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'd250, CHECK_MODEL, '0, '0, '0, 1'b0},
      // exactly at the duration: still eased, not finished
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'd500, CHECK_MODEL, '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'd1, CHECK_GIVEN,
        POS_MAX, POS_MIN, NEG_ONE, 1'b1},
      '{ROW_REG, CSR_EASE_MODE, 32'(MODE_INOUT), OP_ADVANCE, 16'd0, CHECK_NONE,
        '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_RESTART, 16'd0, CHECK_NONE, '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'd250, CHECK_MODEL, '0, '0, '0, 1'b0},
      // midpoint of in-out: second half takes over
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'd250, CHECK_MODEL, '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'd499, CHECK_MODEL, '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'd1, CHECK_MODEL, '0, '0, '0, 1'b0},
      '{ROW_TICK, CSR_EASE_MODE, '0, OP_ADVANCE, 16'd1, CHECK_GIVEN,
        POS_MAX, POS_MIN, NEG_ONE, 1'b1}
   };

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [POS_W-1:0]              csr_wdata = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_opcode = 1'b0;
   logic [STEP_W-1:0]             req_time_step = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [POS_W-1:0]       rsp_pos_x;
   logic signed [POS_W-1:0]       rsp_pos_y;
   logic signed [POS_W-1:0]       rsp_pos_z;
   logic                          rsp_finished;
   logic [AXES-1:0][POS_W-1:0]    rsp_pos;

   // tween state as the block should hold it
   mode_type                      ease_sel = MODE_IN;
   logic [DUR_W-1:0]              span_len = 1;
   logic signed [POS_W-1:0]       from_pos [AXES] = '{default: '0};
   logic signed [POS_W-1:0]       to_pos [AXES] = '{default: '0};
   logic [ELAPSED_W-1:0]          elapsed_acc = '0;
   bit                            armed = 1'b1;

   pos_beat_type                  pending_pos [$];
   int                            mismatches = 0;
   int                            quiet_cycles = 0;
   bit                            gaps_on = 1'b1;

   assign rsp_pos = {rsp_pos_z, rsp_pos_y, rsp_pos_x};

   quartic_ease_position_tween u_dut (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_opcode    (req_opcode),
      .req_time_step (req_time_step),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pos_x     (rsp_pos_x),
      .rsp_pos_y     (rsp_pos_y),
      .rsp_pos_z     (rsp_pos_z),
      .rsp_finished  (rsp_finished)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint unsigned quart4(input longint unsigned a);
      longint unsigned sq;
      sq = (a * a) >> ALPHA_FRAC_BITS;
      return (sq * sq) >> ALPHA_FRAC_BITS;
   endfunction

   function automatic longint unsigned progress(input int frac);
      longint unsigned num;
      if (span_len == '0) return 64'd1 << frac;
      num = elapsed_acc;
      return (num << frac) / span_len;
   endfunction

   // floor of the scaled difference, then clamp to 32 bits
   function automatic logic [POS_W-1:0] blend(input logic signed [POS_W-1:0] a,
                                              input logic signed [POS_W-1:0] b,
                                              input longint unsigned f);
      longint r;
      r = longint'(a) + (((longint'(b) - longint'(a)) * longint'(f)) >>> ALPHA_FRAC_BITS);
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      else if (r < -64'sd2147483648) r = -64'sd2147483648;
      return r[POS_W-1:0];
   endfunction

   function automatic void load_reg(input csr_index_type idx, input logic [POS_W-1:0] val);
      case (idx)
         CSR_EASE_MODE: ease_sel = mode_type'(val[1:0]);
         CSR_DURATION:  span_len = val;
         CSR_START_X:   from_pos[0] = val;
         CSR_START_Y:   from_pos[1] = val;
         CSR_START_Z:   from_pos[2] = val;
         CSR_END_X:     to_pos[0] = val;
         CSR_END_Y:     to_pos[1] = val;
         CSR_END_Z:     to_pos[2] = val;
         default:       ;
      endcase
   endfunction

   function automatic bit advance_tween(input logic op, input logic [STEP_W-1:0] step,
                                        output pos_beat_type beat);
      longint unsigned one, f, v;
      beat = '0;
      one = 64'd1 << ALPHA_FRAC_BITS;
      if (op == OP_RESTART) begin
         elapsed_acc = '0;
         armed = 1'b1;
         return 1'b0;
      end
      if (!armed) return 1'b0;
      elapsed_acc = elapsed_acc + step;
      if (elapsed_acc > span_len) begin
         armed = 1'b0;
         for (int a = 0; a < AXES; a++) beat.pos[a] = to_pos[a];
         beat.done = 1'b1;
         return 1'b1;
      end
      if (ease_sel == MODE_ZERO) return 1'b1;
      case (ease_sel)
         MODE_IN:  f = quart4(progress(ALPHA_FRAC_BITS));
         MODE_OUT: f = one - quart4(one - progress(ALPHA_FRAC_BITS));
         default: begin
            v = progress(ALPHA_FRAC_BITS + 1);
            if (v < one) f = quart4(v) >> 1;
            else f = one - (quart4(2 * one - v) >> 1);
         end
      endcase
      for (int a = 0; a < AXES; a++) beat.pos[a] = blend(from_pos[a], to_pos[a], f);
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatches++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [POS_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      load_reg(idx, val);
   endtask

   // hold requests until every pending beat is back and the block is quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (pending_pos.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_tick(input logic op, input logic [STEP_W-1:0] step,
                            input check_kind_type chk, input pos_beat_type given);
      pos_beat_type calc;
      bit           has_beat;
      if (gaps_on && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 45)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_time_step <= step;
      do @(posedge clock); while (req_stall);
      has_beat = advance_tween(op, step, calc);
      if (chk == CHECK_GIVEN) pending_pos.push_back(given);
      else if (chk == CHECK_MODEL && has_beat) pending_pos.push_back(calc);
   endtask

   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= gaps_on && ($urandom_range(99) < 38);
   end

   always @(posedge clock) begin
      pos_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_pos.size() == 0) begin
            report_mismatch("result beat with nothing pending");
         end else begin
            want = pending_pos.pop_front();
            for (int a = 0; a < AXES; a++)
               if (rsp_pos[a] !== want.pos[a])
                  report_mismatch($sformatf("axis %0d position got %0d, want %0d", a,
                                            $signed(rsp_pos[a]), $signed(want.pos[a])));
            if (rsp_finished !== want.done)
               report_mismatch($sformatf("finished got %b, want %b",
                                         rsp_finished, want.done));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      script_row_type   row;
      pos_beat_type     given;
      bit               prev_reg;
      int               phase;
      int               counted;
      int               ticks;
      int               r;
      logic             op;
      logic [STEP_W-1:0] step;
      longint unsigned  base;
      logic [POS_W-1:0] val;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      prev_reg = 1'b0;
      for (int i = 0; i < SCRIPT_LEN; i++) begin
         row = SCRIPT[i];
         if (row.kind == ROW_REG) begin
            if (!prev_reg) settle();
            write_reg(row.idx, row.data);
         end else begin
            given.pos  = {row.want_z, row.want_y, row.want_x};
            given.done = row.want_done;
            send_tick(row.op, row.step, row.chk, given);
         end
         prev_reg = (row.kind == ROW_REG);
      end

      phase   = 0;
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         phase++;
         gaps_on = !(phase >= 4 && phase <= 6);
         settle();
         write_reg(CSR_EASE_MODE, 32'($urandom_range(MODE_IN, MODE_ZERO)));
         r = $urandom_range(99);
         if (r < 5) val = '0;
         else if (r < 10) val = '1;
         else if (r < 15) val = 32'd1;
         else if (r < 55) val = $urandom_range(2, 500);
         else if (r < 85) val = $urandom_range(501, 200000);
         else val = $urandom;
         write_reg(CSR_DURATION, val);
         for (int i = CSR_START_X; i <= CSR_END_Z; i++) begin
            if ($urandom_range(99) < 60) begin
               r = $urandom_range(99);
               if (r < 10) val = POS_MIN;
               else if (r < 20) val = POS_MAX;
               else if (r < 30) val = '0;
               else val = $urandom;
               write_reg(csr_index_type'(i), val);
            end
         end

         ticks = $urandom_range(20, 90);
         for (int t = 0; t < ticks; t++) begin
            r = $urandom_range(99);
            if (!armed) op = ($urandom_range(99) < 80) ? OP_RESTART : OP_ADVANCE;
            else op = (r < 4) ? OP_RESTART : OP_ADVANCE;
            if (r < 16) begin
               step = $urandom_range(0, 65535);
            end else if (r < 19) begin
               step = '0;
            end else if (r < 22) begin
               step = '1;
            end else begin
               // spread the move over roughly 2 to 40 ticks
               base = span_len / $urandom_range(2, 40);
               base = base + $urandom_range(0, 3);
               step = (base > 65535) ? '1 : base[STEP_W-1:0];
            end
            counted++;
            send_tick(op, step, CHECK_MODEL, '0);
            if ($urandom_range(199) == 0) settle();
         end
      end

      settle();
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
